FILE: sv/sfs_pkg.sv
// shared constants, types and helpers for the slice flow statistics core
package sfs_pkg;

   localparam int VALUE_W         = 32;
   localparam int SUM_W           = 49;
   localparam int ALU_W           = SUM_W + 1;
   localparam int CNT_W           = 17;
   localparam int SLICE_W         = 10;
   localparam int WIDTH_W         = 11;
   localparam int VOXEL_W         = 24;
   localparam int ENABLE_W        = 6;
   localparam int FIELD_N         = 6;
   localparam int MINMAX_N        = 3;
   localparam int MAX_SLICES      = 1024;
   localparam int MAX_SLICE_CELLS = 65536;
   localparam int CELL_TYPE_W     = 8;
   localparam int CELL_SOLID      = 1;
   localparam int KIND_W          = 2;
   localparam int PROD_W          = SLICE_W + 3 + VOXEL_W + 1;
   localparam int DIV_CNT_W       = $clog2(SUM_W);

   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = VOXEL_W;

   localparam int REQ_TDATA_W     = FIELD_N * VALUE_W;
   localparam int RSP_FIELDS_W    = SLICE_W + VALUE_W + 2 * CNT_W + 3 * VALUE_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W       = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH   = 2'd0,
      CSR_VOXEL_SIZE   = 2'd1,
      CSR_FIELD_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SPEED     = 2'd0,
      KIND_PRESSURE  = 2'd1,
      KIND_VORTICITY = 2'd2,
      KIND_VELOCITY  = 2'd3
   } rec_kind_type;

   // clamp a wide signed result to the value range
   function automatic logic signed [VALUE_W-1:0] sat_value(input logic [ALU_W-1:0] v);
      logic signed [VALUE_W-1:0] r;
      if (!v[ALU_W-1] && (|v[ALU_W-2:VALUE_W-1])) begin
         r = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v[ALU_W-1] && !(&v[ALU_W-2:VALUE_W-1])) begin
         r = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/slice_flow_statistics_core.sv
// slice flow statistics core: per-slice min, max and mean over a cell stream
//
//   channel   dir   handshake              payload
//   req_*     in    req_tvalid/req_tready  tdata six Q16.16 values, tuser cell type,
//                                          tlast slice end
//   rsp_*     out   rsp_tvalid/rsp_tready  tdata slice record, tuser record kind,
//                                          tlast fourth record
//   csr_*     in    csr_we                 csr_index, csr_wdata
//
// a solid or overflow cell skips the adder; a fluid cell sends one field per cycle
// through the shared 50-bit adder
// a slice-ending cell then computes the world position (multiply, magnitude, sign), then each mean
// (six means, one quotient bit per cycle on the same adder), skipped for an empty slice
// then four records go out, one per rsp handshake; req_tready stays low until the last
// reset is synchronous and clears counters, extremes, sums and the slice index, and sets the csr defaults
// a stalled rsp side just holds the current record; only csr writes still take effect meanwhile
module slice_flow_statistics_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // speed, pressure, vorticity, vel_x, vel_y, vel_z from bit 0 up
   input  logic [sfs_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // cell class byte
   input  logic [sfs_pkg::CELL_TYPE_W-1:0]       req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // slice index, world x, fluid count, solid count, value a, value b, value c, zero pad
   output logic [sfs_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // record_kind
   output logic [sfs_pkg::KIND_W-1:0]            rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sfs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACCUM,
      S_WORLD_MUL,
      S_WORLD_ABS,
      S_WORLD_SIGN,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_SIGN,
      S_EMIT
   } state_type;

   // control and accumulator state
   state_type                   state_ff, state_in;
   logic [2:0]                  unit_idx_ff, unit_idx_in;
   logic [DIV_CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SLICE_W-1:0]          slice_ctr_ff, slice_ctr_in;
   logic [CNT_W-1:0]            fluid_ff, fluid_in;
   logic [CNT_W-1:0]            solid_ff, solid_in;
   logic signed [VALUE_W-1:0]   min_ff [MINMAX_N];
   logic signed [VALUE_W-1:0]   min_in [MINMAX_N];
   logic signed [VALUE_W-1:0]   max_ff [MINMAX_N];
   logic signed [VALUE_W-1:0]   max_in [MINMAX_N];
   logic signed [SUM_W-1:0]     sum_ff [FIELD_N];
   logic signed [SUM_W-1:0]     sum_in [FIELD_N];
   logic [WIDTH_W-1:0]          grid_width_ff, grid_width_in;
   logic [VOXEL_W-1:0]          voxel_ff, voxel_in;
   logic [ENABLE_W-1:0]         field_en_ff, field_en_in;

   // payload registers
   logic signed [VALUE_W-1:0]   cell_val_ff [FIELD_N];
   logic signed [VALUE_W-1:0]   cell_val_in [FIELD_N];
   logic                        cell_end_ff, cell_end_in;
   logic [SUM_W-1:0]            quo_ff, quo_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic                        neg_ff, neg_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [VALUE_W-1:0]   world_ff, world_in;
   logic signed [VALUE_W-1:0]   mean_ff [FIELD_N];
   logic signed [VALUE_W-1:0]   mean_in [FIELD_N];

   // shared adder
   logic [ALU_W-1:0]            alu_a, alu_b, alu_res;
   logic                        alu_sub;

   logic signed [SUM_W-1:0]     sum_sel;
   logic signed [VALUE_W-1:0]   val_sel;
   logic                        en_sel;
   logic [1:0]                  mm_idx;
   logic [WIDTH_W-1:0]          width_clamped;
   logic signed [SLICE_W+2:0]   slice_offset;
   logic [CNT_W:0]              cell_total;
   logic                        req_fire, rsp_fire, no_fluid;
   logic signed [VALUE_W-1:0]   value_a, value_b, value_c;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign no_fluid   = (fluid_ff == '0);
   assign cell_total = {1'b0, fluid_ff} + {1'b0, solid_ff};

   // one index register walks fields, means and records
   assign sum_sel = (unit_idx_ff < 3'(FIELD_N)) ? sum_ff[unit_idx_ff] : '0;
   assign val_sel = (unit_idx_ff < 3'(FIELD_N)) ? cell_val_ff[unit_idx_ff] : '0;
   assign en_sel  = (unit_idx_ff < 3'(FIELD_N)) ? field_en_ff[unit_idx_ff] : 1'b0;
   assign mm_idx  = (unit_idx_ff < 3'(MINMAX_N)) ? unit_idx_ff[1:0] : 2'd0;

   // width of 0 acts as 1, anything above the slice limit as the limit
   always_comb begin
      if (grid_width_ff == '0) begin
         width_clamped = WIDTH_W'(1);
      end else if (grid_width_ff > WIDTH_W'(MAX_SLICES)) begin
         width_clamped = WIDTH_W'(MAX_SLICES);
      end else begin
         width_clamped = grid_width_ff;
      end
   end

   // 2 * slice - width, so the half-width offset stays exact
   assign slice_offset = $signed({2'b00, slice_ctr_ff, 1'b0}) - $signed({2'b00, width_clamped});

   // operand select for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_ACCUM: begin
            // running sum plus the current field value
            alu_a = {{(ALU_W-SUM_W){sum_sel[SUM_W-1]}}, sum_sel};
            alu_b = {{(ALU_W-VALUE_W){val_sel[VALUE_W-1]}}, val_sel};
         end
         S_WORLD_ABS: begin
            // |product| + 1, halved on write-back for round half away from zero
            alu_a   = ALU_W'(1);
            alu_b   = {{(ALU_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            alu_sub = prod_ff[PROD_W-1];
         end
         S_DIV_LOAD: begin
            // dividend = |sum| + count / 2
            alu_a   = ALU_W'(fluid_ff >> 1);
            alu_b   = {{(ALU_W-SUM_W){sum_sel[SUM_W-1]}}, sum_sel};
            alu_sub = sum_sel[SUM_W-1];
         end
         S_DIV_RUN: begin
            // trial subtract of the divisor from the shifted remainder
            alu_a   = ALU_W'({rem_ff, quo_ff[SUM_W-1]});
            alu_b   = ALU_W'(fluid_ff);
            alu_sub = 1'b1;
         end
         S_WORLD_SIGN, S_DIV_SIGN: begin
            // restore the sign of a magnitude
            alu_b   = ALU_W'(quo_ff);
            alu_sub = neg_ff;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      unit_idx_in   = unit_idx_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      slice_ctr_in  = slice_ctr_ff;
      fluid_in      = fluid_ff;
      solid_in      = solid_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      sum_in        = sum_ff;
      grid_width_in = grid_width_ff;
      voxel_in      = voxel_ff;
      field_en_in   = field_en_ff;
      cell_val_in   = cell_val_ff;
      cell_end_in   = cell_end_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      world_in      = world_ff;
      mean_in       = mean_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:   grid_width_in = csr_wdata[WIDTH_W-1:0];
            CSR_VOXEL_SIZE:   voxel_in      = csr_wdata[VOXEL_W-1:0];
            CSR_FIELD_ENABLE: field_en_in   = csr_wdata[ENABLE_W-1:0];
            default: begin
               grid_width_in = grid_width_ff;
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               for (int i = 0; i < FIELD_N; i++) begin
                  cell_val_in[i] = req_tdata[i*VALUE_W +: VALUE_W];
               end
               cell_end_in = req_tlast;
               unit_idx_in = '0;
               // cells past the slice capacity are dropped, slice end still counts
               if (cell_total < (CNT_W+1)'(MAX_SLICE_CELLS)) begin
                  if (req_tuser == CELL_TYPE_W'(CELL_SOLID)) begin
                     solid_in = solid_ff + CNT_W'(1);
                     state_in = req_tlast ? S_WORLD_MUL : S_IDLE;
                  end else begin
                     fluid_in = fluid_ff + CNT_W'(1);
                     state_in = S_ACCUM;
                  end
               end else begin
                  state_in = req_tlast ? S_WORLD_MUL : S_IDLE;
               end
            end
         end
         S_ACCUM: begin
            if (en_sel) begin
               sum_in[unit_idx_ff] = alu_res[SUM_W-1:0];
               if (unit_idx_ff < 3'(MINMAX_N)) begin
                  if (val_sel < min_ff[mm_idx]) min_in[mm_idx] = val_sel;
                  if (val_sel > max_ff[mm_idx]) max_in[mm_idx] = val_sel;
               end
            end
            if (unit_idx_ff == 3'(FIELD_N - 1)) begin
               unit_idx_in = '0;
               state_in    = cell_end_ff ? S_WORLD_MUL : S_IDLE;
            end else begin
               unit_idx_in = unit_idx_ff + 3'd1;
            end
         end
         S_WORLD_MUL: begin
            // slice offset sign-extended, voxel size zero-extended to the product width
            prod_in  = $signed({{(PROD_W-SLICE_W-3){slice_offset[SLICE_W+2]}}, slice_offset})
                       * $signed({{(PROD_W-VOXEL_W){1'b0}}, voxel_ff});
            state_in = S_WORLD_ABS;
         end
         S_WORLD_ABS: begin
            quo_in   = alu_res[ALU_W-1:1];
            neg_in   = prod_ff[PROD_W-1];
            state_in = S_WORLD_SIGN;
         end
         S_WORLD_SIGN: begin
            world_in    = sat_value(alu_res);
            unit_idx_in = '0;
            if (no_fluid) begin
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               state_in = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            quo_in     = alu_res[SUM_W-1:0];
            rem_in     = '0;
            neg_in     = sum_sel[SUM_W-1];
            bit_cnt_in = '0;
            state_in   = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (!alu_res[ALU_W-1]) begin
               rem_in = alu_res[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[CNT_W-2:0], quo_ff[SUM_W-1]};
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            bit_cnt_in = bit_cnt_ff + DIV_CNT_W'(1);
            if (bit_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = S_DIV_SIGN;
            end
         end
         S_DIV_SIGN: begin
            if (unit_idx_ff < 3'(FIELD_N)) begin
               mean_in[unit_idx_ff] = sat_value(alu_res);
            end
            if (unit_idx_ff == 3'(FIELD_N - 1)) begin
               unit_idx_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               unit_idx_in = unit_idx_ff + 3'd1;
               state_in    = S_DIV_LOAD;
            end
         end
         S_EMIT: begin
            if (rsp_fire) begin
               if (unit_idx_ff == 3'(KIND_VELOCITY)) begin
                  // slice done: next slice index, accumulators back to empty
                  rsp_valid_in = 1'b0;
                  unit_idx_in  = '0;
                  state_in     = S_IDLE;
                  if ({1'b0, slice_ctr_ff} + WIDTH_W'(1) >= width_clamped) begin
                     slice_ctr_in = '0;
                  end else begin
                     slice_ctr_in = slice_ctr_ff + SLICE_W'(1);
                  end
                  fluid_in = '0;
                  solid_in = '0;
                  for (int i = 0; i < MINMAX_N; i++) begin
                     min_in[i] = {1'b0, {(VALUE_W-1){1'b1}}};
                     max_in[i] = {1'b1, {(VALUE_W-1){1'b0}}};
                  end
                  for (int i = 0; i < FIELD_N; i++) begin
                     sum_in[i] = '0;
                  end
               end else begin
                  unit_idx_in = unit_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cell_val_ff <= cell_val_in;
      cell_end_ff <= cell_end_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      world_ff    <= world_in;
      mean_ff     <= mean_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         unit_idx_ff   <= '0;
         bit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         slice_ctr_ff  <= '0;
         fluid_ff      <= '0;
         solid_ff      <= '0;
         for (int i = 0; i < MINMAX_N; i++) begin
            min_ff[i] <= {1'b0, {(VALUE_W-1){1'b1}}};
            max_ff[i] <= {1'b1, {(VALUE_W-1){1'b0}}};
         end
         for (int i = 0; i < FIELD_N; i++) begin
            sum_ff[i] <= '0;
         end
         grid_width_ff <= WIDTH_W'(1);
         voxel_ff      <= VOXEL_W'(65536);
         field_en_ff   <= '1;
      end else begin
         state_ff      <= state_in;
         unit_idx_ff   <= unit_idx_in;
         bit_cnt_ff    <= bit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         slice_ctr_ff  <= slice_ctr_in;
         fluid_ff      <= fluid_in;
         solid_ff      <= solid_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         sum_ff        <= sum_in;
         grid_width_ff <= grid_width_in;
         voxel_ff      <= voxel_in;
         field_en_ff   <= field_en_in;
      end
   end

   // record select: an empty slice reports zeros in every value field
   always_comb begin
      if (no_fluid) begin
         value_a = '0;
         value_b = '0;
         value_c = '0;
      end else if (unit_idx_ff == 3'(KIND_VELOCITY)) begin
         value_a = mean_ff[3];
         value_b = mean_ff[4];
         value_c = mean_ff[5];
      end else begin
         value_a = min_ff[mm_idx];
         value_b = max_ff[mm_idx];
         value_c = mean_ff[mm_idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = unit_idx_ff[KIND_W-1:0];
   assign rsp_tlast  = (unit_idx_ff == 3'(KIND_VELOCITY));
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, value_c, value_b, value_a,
                        solid_ff, fluid_ff, world_ff, slice_ctr_ff};

   // the block never takes a request while a record is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a record is pending");

   // last record of a slice empties the counters
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (fluid_ff == '0 && solid_ff == '0))
      else $error("slice counters not cleared after last record");

   // cell count never passes the slice capacity
   assert property (@(posedge clock) disable iff (reset)
      ((CNT_W+1)'(fluid_ff) + (CNT_W+1)'(solid_ff) <= (CNT_W+1)'(MAX_SLICE_CELLS)))
      else $error("slice cell count beyond capacity");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_RUN) |-> (rem_ff < fluid_ff))
      else $error("divider remainder out of range");

endmodule
